@@ sv/pin_change_event_qualifier_core_macros.svh @@
// Assertion macros for the pin change event qualifier checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PIN_CHANGE_EVENT_QUALIFIER_CORE_MACROS_SVH
`define PIN_CHANGE_EVENT_QUALIFIER_CORE_MACROS_SVH

// Same-cycle implication.
`define PCEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pceq_pkg.sv @@
// Package for the pin change event qualifier: item types, line record,
// opcodes and state codes. No dependencies.
package pceq_pkg;

  typedef enum logic [1:0] {
    OP_ATTACH = 2'd0,
    OP_DETACH = 2'd1,
    OP_EVENT  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  localparam logic [1:0] EdgeRise  = 2'b01;
  localparam logic [1:0] EdgeFall  = 2'b10;
  localparam logic [1:0] EdgeBoth  = 2'b00;
  localparam int unsigned LineSlots = 16;

  typedef struct packed {
    op_e         opcode;
    logic [7:0]  pin;
    logic [1:0]  edge_select;
    logic [31:0] debounce_ticks;
    logic        level;
    logic [63:0] now;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        notify;
    logic [7:0]  notify_pin;
    logic        notify_edge;
    logic [63:0] notify_time;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  pin;
    logic [1:0]  edge_sel;
    logic [31:0] debounce;
    logic [63:0] last_time;
  } line_rec_t;

  typedef struct packed {
    logic      we;
    logic      en_set;
    logic      en_clr;
    line_rec_t rec;
  } line_upd_t;

endpackage

@@ sv/pceq_line_ram.sv @@
// Per-line record memory: one write port, one read port, registered read.
// Depends on pceq_pkg for the record type.
module pceq_line_ram import pceq_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Aw    = 4
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [Aw-1:0] rd_addr_i,
  output line_rec_t     rd_data_o,
  input  logic          wr_en_i,
  input  logic [Aw-1:0] wr_addr_i,
  input  line_rec_t     wr_data_i
);

  line_rec_t mem_q [Depth];
  line_rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/pceq_decide.sv @@
// Read-modify-write decision for one item against its line record.
// Depends on pceq_pkg for item, record and update types.
module pceq_decide import pceq_pkg::*; (
  input  in_item_t  item_i,
  input  line_rec_t rec_i,
  input  logic      enabled_i,
  input  logic      in_range_i,
  output out_item_t result_o,
  output line_upd_t upd_o
);

  logic [1:0]  cur_edge;
  logic        edge_ok;
  logic        port_match;
  logic [63:0] elapsed;
  logic        fire;

  always_comb begin
    cur_edge   = item_i.level ? EdgeRise : EdgeFall;
    edge_ok    = ((rec_i.edge_sel & cur_edge) != 2'b00) || (rec_i.edge_sel == EdgeBoth);
    port_match = (rec_i.pin[7:4] == item_i.pin[7:4]);
    elapsed    = item_i.now - rec_i.last_time;
    fire       = (rec_i.debounce == 32'd0) || (elapsed >= {32'd0, rec_i.debounce});

    result_o   = '0;
    upd_o      = '0;
    upd_o.rec  = rec_i;

    if (in_range_i) begin
      unique case (item_i.opcode)
        OP_ATTACH: begin
          if (enabled_i && !port_match) begin
            result_o.status = 1'b1;
          end else begin
            upd_o.we            = 1'b1;
            upd_o.en_set        = 1'b1;
            upd_o.rec.pin       = item_i.pin;
            upd_o.rec.edge_sel  = item_i.edge_select;
            upd_o.rec.debounce  = item_i.debounce_ticks;
            upd_o.rec.last_time = item_i.now;
          end
        end
        OP_DETACH: begin
          upd_o.en_clr = enabled_i && port_match;
        end
        OP_EVENT: begin
          if (enabled_i && edge_ok) begin
            if (rec_i.debounce != 32'd0) begin
              upd_o.we            = 1'b1;
              upd_o.rec.last_time = item_i.now;
            end
            if (fire) begin
              result_o.notify      = 1'b1;
              result_o.notify_pin  = rec_i.pin;
              result_o.notify_edge = item_i.level;
              result_o.notify_time = item_i.now;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/pin_change_event_qualifier_core.sv @@
// Top level of the pin change event qualifier: handshake control, line
// enable bits and output register. Uses pceq_pkg, pceq_line_ram, pceq_decide.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------
//   in      | input     | in_valid_i / in_ready_o | in_item_i
//   out     | output    | out_valid_o/out_ready_i | out_item_o
//
// Each item's line record is read from memory as the item is accepted in idle;
// exec decides it and writes the record back. in_ready_o is high in idle only.
// The result waits in an output register while the next item is accepted;
// an item that finishes while that register is still full holds in exec.
// Reset clears the line enable bits at once; no clearing pass is needed.
module pin_change_event_qualifier_core import pceq_pkg::*; #(
  parameter int unsigned LINE_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned LineAw = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

  state_e          state_q, state_d;
  in_item_t        item_q;
  logic [LINE_COUNT-1:0] enabled_q;
  logic            out_valid_q;
  out_item_t       out_item_q;

  logic            in_fire;
  logic            can_load;
  logic [LineAw-1:0] rd_addr;
  logic [LineAw-1:0] cur_addr;
  logic            in_range;
  line_rec_t       rec;
  out_item_t       result;
  line_upd_t       upd;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign can_load   = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign rd_addr    = in_item_i.pin[LineAw-1:0];
  assign cur_addr   = item_q.pin[LineAw-1:0];
  assign in_range   = ({1'b0, item_q.pin[3:0]} < 5'(LINE_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EXEC;
      ST_EXEC: if (can_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
  end

  pceq_line_ram #(
    .Depth (LINE_COUNT),
    .Aw    (LineAw)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (rec),
    .wr_en_i   (can_load && upd.we),
    .wr_addr_i (cur_addr),
    .wr_data_i (upd.rec)
  );

  pceq_decide u_decide (
    .item_i     (item_q),
    .rec_i      (rec),
    .enabled_i  (enabled_q[cur_addr]),
    .in_range_i (in_range),
    .result_o   (result),
    .upd_o      (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= '0;
    end else if (can_load) begin
      if (upd.en_set) begin
        enabled_q[cur_addr] <= 1'b1;
      end else if (upd.en_clr) begin
        enabled_q[cur_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ sv/pceq_checker.sv @@
// Port-level checks for the pin change event qualifier, bound to the top.
// Depends on pceq_pkg and pin_change_event_qualifier_core_macros.svh.
`include "pin_change_event_qualifier_core_macros.svh"

module pceq_checker import pceq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  `PCEQ_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "out item dropped or changed while stalled")
  `PCEQ_ASSERT_IMPL(a_quiet_fields, out_valid_o && !out_item_o.notify, out_item_o.notify_pin == 8'd0 && !out_item_o.notify_edge && out_item_o.notify_time == 64'd0, "notify fields set without notify")
  `PCEQ_ASSERT_IMPL(a_status_excl, out_valid_o && out_item_o.status, !out_item_o.notify, "sharing violation with notify")
  `PCEQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready while an item is in work")

endmodule

bind pin_change_event_qualifier_core pceq_checker u_pceq_checker (.*);
